@@ rtl/core/srt_pkg.sv @@
// Shared types and constants for the segment reference-count table.
// Used by srt_slot_ram, srt_ctrl and segment_refcount_table_unit.
package srt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int REFS_W  = 32;

  localparam logic [REFS_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_FULL      = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] length;
    logic [REFS_W-1:0] refs;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    slot_t            wr_data;
  } ram_req_t;

  typedef struct packed {
    status_t           status;
    logic [REFS_W-1:0] ref_count;
    logic              released;
    logic [ADDR_W-1:0] release_base;
    logic [SIZE_W-1:0] release_size;
  } result_t;

endpackage

@@ rtl/core/srt_slot_ram.sv @@
// Slot storage: base, length and count per slot, one read and one write port.
// Read data is registered. Depends on srt_pkg.
module srt_slot_ram
  import srt_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output slot_t    rd_data
);

  slot_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_idx];
    end
  end

endmodule

@@ rtl/core/srt_ctrl.sv @@
// Sequencer: scans the slot RAM for a match, then updates at most one slot.
// Holds the slot valid bits. Depends on srt_pkg and the srt_slot_ram port.
module srt_ctrl
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [SIZE_W-1:0] in_segment_size,
  output ram_req_t          ram_req,
  input  slot_t             ram_rd_data,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  slot_t              hit_slot_r, hit_slot_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;

  logic              accept;
  logic              issue;
  logic [ADDR_W-1:0] offset;
  logic              in_range;
  logic              fire;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign issue    = (state_r == S_SCAN) && (issue_cnt_r < CNT_W'(ENTRIES));
  assign offset   = addr_r - ram_rd_data.base;
  assign in_range = valid_r[cmp_idx_r] && (addr_r >= ram_rd_data.base) &&
                    (offset < {{(ADDR_W-SIZE_W){1'b0}}, ram_rd_data.length});
  assign res_valid = (state_r == S_FINISH);
  assign fire      = res_valid && res_take;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    issue_cnt_nxt  = issue_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;

    ram_req.rd_en   = issue;
    ram_req.rd_idx  = issue_cnt_r[IDX_W-1:0];
    ram_req.wr_en   = 1'b0;
    ram_req.wr_idx  = hit_idx_r;
    ram_req.wr_data = hit_slot_r;

    res.status       = ST_NOT_FOUND;
    res.ref_count    = '0;
    res.released     = 1'b0;
    res.release_base = '0;
    res.release_size = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_operation;
          addr_nxt       = in_address;
          size_nxt       = in_segment_size;
          issue_cnt_nxt  = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          // zero-size add and unused codes need no lookup
          if ((in_operation == OP_ADD && in_segment_size == '0) ||
              (in_operation != OP_ADD && in_operation != OP_INC &&
               in_operation != OP_DEC)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_cnt_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (in_range) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = cmp_idx_r;
            hit_slot_nxt = ram_rd_data;
            state_nxt    = S_FINISH;
          end else begin
            if (!valid_r[cmp_idx_r] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        unique case (op_r)
          OP_ADD, OP_INC: begin
            if (op_r == OP_ADD && size_r == '0) begin
              res.status = ST_MISMATCH;
            end else if (hit_r) begin
              if (op_r == OP_ADD && hit_slot_r.length != size_r) begin
                res.status = ST_MISMATCH;
              end else if (hit_slot_r.refs == COUNT_MAX) begin
                res.status    = ST_SATURATED;
                res.ref_count = COUNT_MAX;
              end else begin
                res.status           = ST_OK;
                res.ref_count        = hit_slot_r.refs + REFS_W'(1);
                ram_req.wr_en        = fire;
                ram_req.wr_data.refs = hit_slot_r.refs + REFS_W'(1);
              end
            end else if (op_r == OP_ADD) begin
              if (free_found_r) begin
                res.status              = ST_OK;
                res.ref_count           = REFS_W'(1);
                ram_req.wr_en           = fire;
                ram_req.wr_idx          = free_idx_r;
                ram_req.wr_data.base    = addr_r;
                ram_req.wr_data.length  = size_r;
                ram_req.wr_data.refs    = REFS_W'(1);
                if (fire) begin
                  valid_nxt[free_idx_r] = 1'b1;
                end
              end else begin
                res.status = ST_FULL;
              end
            end
          end
          OP_DEC: begin
            if (hit_r) begin
              res.status = ST_OK;
              if (hit_slot_r.refs <= REFS_W'(1)) begin
                res.released     = 1'b1;
                res.release_base = hit_slot_r.base;
                res.release_size = hit_slot_r.length;
                if (fire) begin
                  valid_nxt[hit_idx_r] = 1'b0;
                end
              end else begin
                res.ref_count        = hit_slot_r.refs - REFS_W'(1);
                ram_req.wr_en        = fire;
                ram_req.wr_data.refs = hit_slot_r.refs - REFS_W'(1);
              end
            end
          end
          default: begin
            res.status = ST_NOT_FOUND;
          end
        endcase
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_cnt_r  <= issue_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
  end

endmodule

@@ rtl/core/segment_refcount_table_unit.sv @@
// Top level of the segment reference-count table: sequencer, slot RAM, output register.
// Depends on srt_pkg, srt_slot_ram and srt_ctrl.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_operation, in_address,
//           |           | in_segment_size
//   out     | output    | out_valid, out_stall, out_status, out_ref_count,
//           |           | out_released, out_release_base, out_release_size
//
// One transaction at a time. A lookup issues one slot RAM read per cycle, lowest index
// first, and compares each slot in the cycle after its read; it stops at the first
// match. A miss walks all ENTRIES slots; an early match ends the scan sooner, and a
// zero-size add or an unused operation code skips the scan. The single read port
// of the slot RAM sets the pace.
// A synchronous reset clears the valid bits; slot contents are left as they are.
// The output register holds one result, so a new input transaction is taken while the
// previous result is stalled; the next write-back waits until that register drains.
module segment_refcount_table_unit
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [SIZE_W-1:0] in_segment_size,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [REFS_W-1:0] out_ref_count,
  output logic              out_released,
  output logic [ADDR_W-1:0] out_release_base,
  output logic [SIZE_W-1:0] out_release_size
);

  ram_req_t ram_req;
  slot_t    ram_rd_data;
  logic     res_valid;
  logic     res_take;
  result_t  res;

  logic     out_valid_r, out_valid_nxt;
  result_t  out_res_r;

  srt_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  srt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_address      (in_address),
    .in_segment_size (in_segment_size),
    .ram_req         (ram_req),
    .ram_rd_data     (ram_rd_data),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res)
  );

  // result register is free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_ref_count    = out_res_r.ref_count;
  assign out_released     = out_res_r.released;
  assign out_release_base = out_res_r.release_base;
  assign out_release_size = out_res_r.release_size;

endmodule
